@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ src/mbd_pkg.sv @@
`timescale 1ns / 1ps

package mbd_pkg;

    localparam int DEB_W        = 8;
    localparam int FOOT_CNT_W   = 3;
    localparam int FOOT_W       = 4;
    localparam int STABLE_W     = 5;
    localparam int LED_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 16;

    typedef enum logic [1:0] {
        LED_NORMAL = 2'd0,
        LED_INVERT = 2'd1,
        LED_ON     = 2'd2,
        LED_HOLD   = 2'd3
    } t_led_mode;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_FOOT = 2'd2;

    typedef struct packed {
        logic [DEB_W-1:0]      debounce;
        t_led_mode             led_mode;
        logic [FOOT_CNT_W-1:0] active_foot;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic clear;
    } t_chan_ctl;

endpackage

@@ src/mbd_cfg_regs.sv @@
`timescale 1ns / 1ps

module mbd_cfg_regs
    import mbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (i_index)
                CFG_DEBOUNCE:    n_cfg.debounce    = i_data[DEB_W-1:0];
                CFG_LED_MODE:    n_cfg.led_mode    = t_led_mode'(i_data[1:0]);
                CFG_ACTIVE_FOOT: n_cfg.active_foot = i_data[FOOT_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce    <= '0;
            r_cfg.led_mode    <= LED_NORMAL;
            r_cfg.active_foot <= FOOT_CNT_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/mbd_channel.sv @@
`timescale 1ns / 1ps

module mbd_channel
    import mbd_pkg::*;
#(
    parameter bit HAS_LED = 1'b1
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_chan_ctl i_ctl,
    input  logic      i_sample,
    output logic      o_stable,
    output logic      o_led
);

    logic             r_last;
    logic             r_stable;
    logic [DEB_W-1:0] r_cnt;
    logic             n_last;
    logic             n_stable;
    logic [DEB_W-1:0] n_cnt;
    logic             w_settle;

    always_comb begin
        n_last   = r_last;
        n_stable = r_stable;
        n_cnt    = r_cnt;
        w_settle = 1'b0;
        if (i_ctl.clear) begin
            n_last   = 1'b0;
            n_stable = 1'b0;
            n_cnt    = i_cfg.debounce;
        end else if (i_ctl.tick) begin
            // reload on an edge, else run the countdown out, then settle
            if ((r_last != i_sample) && (i_cfg.debounce != '0)) begin
                n_cnt = i_cfg.debounce;
            end else if (r_cnt != '0) begin
                n_cnt = r_cnt - DEB_W'(1);
            end else begin
                n_stable = i_sample;
                w_settle = 1'b1;
            end
            n_last = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b0;
            r_stable <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_last   <= n_last;
            r_stable <= n_stable;
            r_cnt    <= n_cnt;
        end
    end

    assign o_stable = r_stable;

    generate
        if (HAS_LED) begin : g_led
            logic r_led;
            logic n_led;

            always_comb begin
                n_led = r_led;
                if (i_ctl.clear) begin
                    n_led = (i_cfg.led_mode == LED_ON);
                end else if (w_settle) begin
                    case (i_cfg.led_mode)
                        LED_NORMAL: n_led = i_sample;
                        LED_INVERT: n_led = ~i_sample;
                        default: ;
                    endcase
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_led <= 1'b0;
                end else begin
                    r_led <= n_led;
                end
            end

            assign o_led = r_led;
        end else begin : g_no_led
            assign o_led = 1'b0;
        end
    endgenerate

endmodule

@@ src/multi_button_debouncer_led.sv @@
// An accepted item passes the input register, then the channel state registers
// that form the result. Throughput: one item per cycle while the master side is
// ready; every channel updates in parallel in one pass.
// The result register stays put while the master side stalls; the input register
// still takes one more item meanwhile.
// Reset (i_rst_n low, synchronous): both sides empty, channel state and LEDs
// cleared, debounce_ticks 0, led_mode normal, active_foot_buttons 1.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_button_debouncer_led
    import mbd_pkg::*;
#(
    parameter int NUM_CHANNELS = 5
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] onboard_level, [4:1] foot_levels, [7:5] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic                   s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [4:0] stable_buttons, [8:5] led_on, [15:9] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Input register: one item parked ahead of the channel update.
    logic              r_in_valid;
    t_op               r_in_op;
    logic              r_in_onboard;
    logic [FOOT_W-1:0] r_in_foot;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_accept;
    logic              w_advance;
    t_cfg              w_cfg;

    logic [NUM_CHANNELS-1:0] w_stable;
    logic [NUM_CHANNELS-1:0] w_led;
    logic [STABLE_W-1:0]     w_stable_out;
    logic [LED_W-1:0]        w_led_out;

    // Config writes land at once; the user must keep the block idle then (unchecked).
    assign o_cfg_ready = 1'b1;

    mbd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // Advance the parked item into the channel state whenever the result slot
    // is empty or being drained this cycle.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload holds without reset; loaded only on accept.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op      <= t_op'(s_axis_tuser);
            r_in_onboard <= s_axis_tdata[0];
            r_in_foot    <= s_axis_tdata[FOOT_W:1];
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // One debounce slice per channel. Channel 0 is the onboard button (active
    // low pin), channels 1..4 the foot pins, any further channel samples zero.
    // A channel ticks when it is the onboard one or its foot number is within
    // active_foot_buttons; a larger count saturates by itself; every channel clears.
    generate
        for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
            t_chan_ctl w_ctl;
            logic      w_sample;
            logic      w_active;

            if (g == 0) begin : g_onboard
                assign w_sample = ~r_in_onboard;
            end else if (g <= FOOT_W) begin : g_foot
                assign w_sample = r_in_foot[g-1];
            end else begin : g_nopin
                assign w_sample = 1'b0;
            end

            assign w_active    = (g == 0) || (int'(w_cfg.active_foot) >= g);
            assign w_ctl.tick  = w_advance && (r_in_op == OP_TICK) && w_active;
            assign w_ctl.clear = w_advance && (r_in_op == OP_CLEAR);

            mbd_channel #(
                .HAS_LED (g != 0)
            ) u_chan (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_cfg    (w_cfg),
                .i_ctl    (w_ctl),
                .i_sample (w_sample),
                .o_stable (w_stable[g]),
                .o_led    (w_led[g])
            );
        end

        // Drop channel bits beyond the result fields; zero fields with no channel.
        for (genvar b = 0; b < STABLE_W; b++) begin : g_stable_bit
            if (b < NUM_CHANNELS) begin : g_has
                assign w_stable_out[b] = w_stable[b];
            end else begin : g_none
                assign w_stable_out[b] = 1'b0;
            end
        end

        for (genvar k = 0; k < LED_W; k++) begin : g_led_bit
            if (k + 1 < NUM_CHANNELS) begin : g_has
                assign w_led_out[k] = w_led[k+1];
            end else begin : g_none
                assign w_led_out[k] = 1'b0;
            end
        end
    endgenerate

    // The channel state registers are the result register: they only change
    // on advance, which requires the result slot to be free.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - STABLE_W - LED_W){1'b0}}, w_led_out, w_stable_out};

    `ASSERT_ON(a_result_holds, !w_advance |=> $stable(m_axis_tdata), "result changed without advance")
    `ASSERT_ON(a_no_overwrite, (r_in_valid && !w_advance) |-> !w_accept, "input register overwritten")
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!m_axis_tvalid && !r_in_valid), "not empty after reset")
    `ASSERT_ON(a_clear_stable, (w_advance && (r_in_op == OP_CLEAR)) |=> (w_stable_out == '0), "clear left a stable button set")

endmodule

@@ sim/mbd_checker.sv @@
`timescale 1ns / 1ps

module mbd_checker
    import mbd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic                   i_in_op,

    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [OUT_TDATA_W-1:0] i_out_data,

    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,

    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int NUM_CH    = 5;
    localparam int RESULT_W  = STABLE_W + LED_W;

    typedef struct packed {
        logic [LED_W-1:0]    led;
        logic [STABLE_W-1:0] stable;
    } t_buttons;

    t_buttons buttons_due[$];

    logic [DEB_W-1:0]      deb_ticks;
    t_led_mode             led_mode;
    logic [FOOT_CNT_W-1:0] foot_cnt;

    logic                  last_smp  [NUM_CH];
    logic                  stable_st [NUM_CH];
    logic [DEB_W-1:0]      count_dn  [NUM_CH];
    logic                  led_st    [NUM_CH-1];

    int                    fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Advance the channels by one item and return the debounced view.
    function automatic t_buttons advance_buttons(t_op op, logic onboard,
                                                 logic [FOOT_W-1:0] foot);
        int       c;
        int       active;
        logic     smp;
        t_buttons res;
        if (op == OP_CLEAR) begin
            for (c = 0; c < NUM_CH; c++) begin
                last_smp[c]  = 1'b0;
                stable_st[c] = 1'b0;
                count_dn[c]  = deb_ticks;
            end
            for (c = 0; c < NUM_CH - 1; c++) begin
                led_st[c] = (led_mode == LED_ON);
            end
        end else begin
            active = int'(foot_cnt) + 1;
            if (active > NUM_CH) begin
                active = NUM_CH;
            end
            for (c = 0; c < active; c++) begin
                if (c == 0) begin
                    smp = ~onboard;
                end else begin
                    smp = foot[c-1];
                end
                if (last_smp[c] != smp && deb_ticks != '0) begin
                    count_dn[c] = deb_ticks;
                end else if (count_dn[c] != '0) begin
                    count_dn[c] = count_dn[c] - 1'b1;
                end else begin
                    stable_st[c] = smp;
                    if (c > 0) begin
                        case (led_mode)
                            LED_NORMAL: led_st[c-1] = smp;
                            LED_INVERT: led_st[c-1] = ~smp;
                            default: ;
                        endcase
                    end
                end
                last_smp[c] = smp;
            end
        end
        for (c = 0; c < STABLE_W; c++) begin
            res.stable[c] = stable_st[c];
        end
        for (c = 0; c < LED_W; c++) begin
            res.led[c] = led_st[c];
        end
        return res;
    endfunction

    function automatic void report_mismatch(string what, logic [15:0] want,
                                            logic [15:0] seen);
        fails++;
        if (fails <= 10) begin
            $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, seen);
        end
    endfunction

    always @(posedge i_clk) begin
        t_buttons want;
        t_buttons seen;
        if (!i_rst_n) begin
            deb_ticks = '0;
            led_mode  = LED_NORMAL;
            foot_cnt  = FOOT_CNT_W'(1);
            for (int c = 0; c < NUM_CH; c++) begin
                last_smp[c]  = 1'b0;
                stable_st[c] = 1'b0;
                count_dn[c]  = '0;
            end
            for (int c = 0; c < NUM_CH - 1; c++) begin
                led_st[c] = 1'b0;
            end
            buttons_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE:    deb_ticks = i_cfg_data;
                    CFG_LED_MODE:    led_mode  = t_led_mode'(i_cfg_data[1:0]);
                    CFG_ACTIVE_FOOT: foot_cnt  = i_cfg_data[FOOT_CNT_W-1:0];
                    default: ;
                endcase
            end
            // compare before queuing so a result can never match its own item
            if (i_out_valid && i_out_ready) begin
                seen = i_out_data[RESULT_W-1:0];
                if (buttons_due.size() == 0) begin
                    report_mismatch("unexpected result", '0, i_out_data);
                end else begin
                    want = buttons_due.pop_front();
                    if (seen.stable !== want.stable) begin
                        report_mismatch("stable_buttons", 16'(want.stable), 16'(seen.stable));
                    end
                    if (seen.led !== want.led) begin
                        report_mismatch("led_on", 16'(want.led), 16'(seen.led));
                    end
                    if (i_out_data[OUT_TDATA_W-1:RESULT_W] !== '0) begin
                        report_mismatch("tdata padding", '0, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                buttons_due.push_back(advance_buttons(t_op'(i_in_op), i_in_data[0],
                                                      i_in_data[FOOT_W:1]));
            end
        end
        o_fail_count <= fails;
        o_pending    <= buttons_due.size();
    end

endmodule

@@ sim/tb_multi_button_debouncer_led.sv @@
`timescale 1ns / 1ps

module tb_multi_button_debouncer_led;
    import mbd_pkg::*;

    // Longest stretch with no handshake on any channel before the run is
    // declared hung; well above the long output hold-off below.
    localparam int STALL_LIMIT = 2000;
    // Length of the deliberate output hold-off that fills the block up.
    localparam int HOLD_CYCLES = 150;
    localparam int IN_PAD_W    = IN_TDATA_W - FOOT_W - 1;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    int                     fail_count;
    int                     pending;

    // Shared between the sender and the receiver: odds of an idle burst
    // (0 means none) and a one-shot request for the long output hold-off.
    int                     idle_odds     = 0;
    bit                     hold_req      = 1'b0;

    // Current raw pin levels of the random part: bit 0 onboard, 4:1 foot.
    logic [4:0]             pins          = '0;
    logic [DEB_W-1:0]       cur_deb       = '0;

    int                     stall_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    multi_button_debouncer_led dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    mbd_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_op      (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offer one item and hold it until the block takes it. An optional idle
    // burst goes in front; no_gap suppresses it so the sender keeps pushing.
    task automatic send_sample(t_op op, logic onboard, logic [FOOT_W-1:0] foot,
                               bit no_gap);
        if (!no_gap && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{IN_PAD_W{1'b0}}, foot, onboard};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop the input valid and wait until every expected result is in, then
    // let the pipeline run dry. The first edge makes the pending count
    // reflect the last accepted item.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Reconfigure between phases, only once the block has gone quiet.
    task automatic apply_settings(logic [DEB_W-1:0] deb, t_led_mode mode,
                                  logic [FOOT_CNT_W-1:0] foot);
        settle_idle();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LED_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_ACTIVE_FOOT, CFG_DATA_W'(foot));
        i_cfg_valid <= 1'b0;
        cur_deb = deb;
    endtask

    // Button activity: pins hold their level for stretches that scale with the
    // debounce time so countdowns can run out, with optional single-item
    // glitches and occasional clears. The first quiet_n items go back to back.
    task automatic run_press_sequence(int n, int toggle_span, int glitch_odds,
                                      int clear_odds, int quiet_n);
        int         i;
        int         k;
        logic [4:0] smp;
        for (i = 0; i < n; i++) begin
            if (clear_odds != 0 && $urandom_range(1, clear_odds) == 1) begin
                send_sample(OP_CLEAR, 1'($urandom), FOOT_W'($urandom), i < quiet_n);
            end else begin
                if ($urandom_range(0, toggle_span) == 0) begin
                    k = $urandom_range(0, 4);
                    pins[k] = ~pins[k];
                end
                smp = pins;
                if (glitch_odds != 0 && $urandom_range(1, glitch_odds) == 1) begin
                    k = $urandom_range(0, 4);
                    smp[k] = ~smp[k];
                end
                send_sample(OP_TICK, smp[0], smp[4:1], i < quiet_n);
            end
        end
    endtask

    // Output side: ready by default, random stall bursts, and one long
    // hold-off on request so the input side backs up. Each burst also spans the
    // loop edge.
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Hang detection: count cycles in which no channel moves anything.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int               ph;
        int               n_items;
        int               span;
        int               glitch_odds;
        logic [DEB_W-1:0] deb;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: no debounce, normal LEDs, one foot button.
        idle_odds = 4;
        send_sample(OP_TICK, 1'b1, 4'h0, 1'b0);
        send_sample(OP_TICK, 1'b0, 4'hF, 1'b0);
        send_sample(OP_TICK, 1'b1, 4'h5, 1'b0);
        send_sample(OP_TICK, 1'b0, 4'hA, 1'b0);
        send_sample(OP_CLEAR, 1'b1, 4'hF, 1'b0);
        send_sample(OP_TICK, 1'b0, 4'hF, 1'b0);

        // Inverted LEDs on all four foot buttons.
        apply_settings(8'd0, LED_INVERT, 3'd4);
        send_sample(OP_TICK, 1'b0, 4'hF, 1'b0);
        send_sample(OP_TICK, 1'b1, 4'h0, 1'b0);
        send_sample(OP_CLEAR, 1'b0, 4'h0, 1'b0);
        send_sample(OP_TICK, 1'b1, 4'h5, 1'b0);

        // Short debounce, LEDs forced on by clear, foot count saturating.
        // Hold the press until the countdown runs out, then bounce once.
        apply_settings(8'd3, LED_ON, 3'd7);
        send_sample(OP_CLEAR, 1'b1, 4'h0, 1'b0);
        repeat (5) send_sample(OP_TICK, 1'b0, 4'hF, 1'b0);
        send_sample(OP_TICK, 1'b1, 4'h0, 1'b0);
        send_sample(OP_TICK, 1'b0, 4'hF, 1'b0);

        // Longest debounce, LEDs left alone, onboard button only.
        apply_settings(8'd255, LED_HOLD, 3'd0);
        send_sample(OP_TICK, 1'b0, 4'hF, 1'b0);
        send_sample(OP_TICK, 1'b1, 4'h0, 1'b0);
        send_sample(OP_CLEAR, 1'b0, 4'hA, 1'b0);
        send_sample(OP_TICK, 1'b0, 4'h5, 1'b0);

        pins = 5'($urandom);
        for (ph = 0; ph < 10; ph++) begin
            n_items     = 95;
            glitch_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(4, 12);
            case ($urandom_range(0, 5))
                0:       deb = 8'd0;
                1:       deb = 8'd1;
                2:       deb = DEB_W'($urandom_range(2, 6));
                3:       deb = DEB_W'($urandom_range(0, 15));
                4:       deb = DEB_W'($urandom_range(7, 20));
                default: deb = DEB_W'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
                0:       idle_odds = 0;
                1:       idle_odds = 3;
                2:       idle_odds = 6;
                default: idle_odds = 10;
            endcase
            // Long clean stretch at the largest debounce so countdowns expire.
            if (ph == 8) begin
                deb         = 8'd255;
                glitch_odds = 0;
                n_items     = 280;
            end
            // Wind down with no idling on either side.
            if (ph == 9) begin
                idle_odds = 0;
            end
            apply_settings(deb, t_led_mode'($urandom_range(0, 3)),
                           FOOT_CNT_W'($urandom_range(0, 7)));
            span = int'(cur_deb) + 2;
            if (ph == 1) begin
                // Stall the output for a long stretch while items keep coming.
                hold_req = 1'b1;
                run_press_sequence(n_items, span, glitch_odds, 50, 40);
            end else if (ph == 8) begin
                run_press_sequence(n_items, 350, glitch_odds, 0, 0);
            end else begin
                run_press_sequence(n_items, span, glitch_odds, 50, 0);
            end
        end

        settle_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/mbd_pkg.sv
src/mbd_cfg_regs.sv
src/mbd_channel.sv
src/multi_button_debouncer_led.sv
sim/mbd_checker.sv
sim/tb_multi_button_debouncer_led.sv
